@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the binomial sampler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked at every clock edge outside reset
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every clock edge, reset included
`define ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/bitsmp_pkg.sv @@
// Package: shared constants, datapath operation codes and status type
`default_nettype none
package bitsmp_pkg;
  localparam int MAX_TRIALS_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 46;

  localparam int TW     = 11;   // trials / count width
  localparam int UW     = 32;   // uniform fraction width
  localparam int PW     = 32;   // probability width
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_TRIALS  = 2'd0;
  localparam logic [1:0] REG_PROB    = 2'd1;
  localparam logic [1:0] REG_REFLECT = 2'd2;

  localparam logic [TW-1:0] TRIALS_RST  = 11'd1;
  localparam logic [PW-1:0] PROB_RST    = 32'h8000_0000;
  localparam logic          REFLECT_RST = 1'b1;
  localparam logic [PW-1:0] HALF_Q32    = 32'h8000_0000;

  typedef logic [3:0] op_t;
  localparam op_t OP_NONE      = 4'd0;
  localparam op_t OP_INIT      = 4'd1;
  localparam op_t OP_MUL_ACC   = 4'd2;
  localparam op_t OP_MUL_SQ    = 4'd3;
  localparam op_t OP_LD_ACC    = 4'd4;
  localparam op_t OP_LD_SQ     = 4'd5;
  localparam op_t OP_DIV_RATIO = 4'd6;
  localparam op_t OP_LD_RATIO  = 4'd7;
  localparam op_t OP_SAT_RATIO = 4'd8;
  localparam op_t OP_LD_ITEM   = 4'd9;
  localparam op_t OP_MUL_STEP  = 4'd10;
  localparam op_t OP_LD_MUL    = 4'd11;
  localparam op_t OP_MUL_SCALE = 4'd12;
  localparam op_t OP_DIV_SCALE = 4'd13;
  localparam op_t OP_LD_DIV    = 4'd14;
  localparam op_t OP_LD_OUT    = 4'd15;

  typedef struct packed {
    logic mexp_zero;
    logic mexp_lsb;
    logic ratio_big;
    logic cont;
    logic mul_done;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/bitsmp_if.sv @@
// Channel interfaces: uniform input and sample output
`default_nettype none
interface bitsmp_in_if;
  import bitsmp_pkg::*;
  logic          valid;
  logic          ready;
  logic [UW-1:0] uniform_frac;
  modport source (output valid, output uniform_frac, input ready);
  modport sink (input valid, input uniform_frac, output ready);
endinterface

interface bitsmp_out_if;
  import bitsmp_pkg::*;
  logic          valid;
  logic          ready;
  logic [TW-1:0] sample_count;
  modport source (output valid, output sample_count, input ready);
  modport sink (input valid, input sample_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bitsmp_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none
`include "assert_macros.svh"
module bitsmp_mul #(
  parameter int W = 48
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic      [2*W-1:0] prod,
  output logic                done
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   a_r, b_r;
  logic [2*W-1:0] p_r, p_nxt;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;
  logic [W:0]     hsum;

  // add the multiplicand into the top half, then shift right
  always_comb begin
    hsum  = {1'b0, p_r[2*W-1:W]} + {1'b0, (b_r[0] ? a_r : {W{1'b0}})};
    p_nxt = {hsum, p_r[W-1:1]};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // operands and partial product
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      b_r <= b_r >> 1;
      p_r <= p_nxt;
    end
  end

  assign prod = p_r;
  assign done = done_r;

  `ASSERT_RST(a_mul_done_after_busy, clk, rst_n, done_r |-> $past(busy_r), "mul done without run")
endmodule
`default_nettype wire

@@ hw/rtl/bitsmp_div.sv @@
// Restoring divider, one quotient bit per cycle
`default_nettype none
`include "assert_macros.svh"
module bitsmp_div #(
  parameter int NW = 79,
  parameter int DW = 33
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic      [NW-1:0] quot,
  output logic               done
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] qd_r, qd_nxt;
  logic [DW-1:0] r_r, r_nxt, d_r;
  logic [DW:0]   rs, diff;
  logic          ge;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    rs     = {r_r, qd_r[NW-1]};
    diff   = rs - {1'b0, d_r};
    ge     = rs >= {1'b0, d_r};
    r_nxt  = ge ? diff[DW-1:0] : rs[DW-1:0];
    qd_nxt = {qd_r[NW-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      qd_r <= dividend;
      r_r  <= '0;
      d_r  <= divisor;
    end else if (busy_r) begin
      qd_r <= qd_nxt;
      r_r  <= r_nxt;
    end
  end

  assign quot = qd_r;
  assign done = done_r;

  `ASSERT_RST(a_div_done_after_busy, clk, rst_n, done_r |-> $past(busy_r), "div done without run")
endmodule
`default_nettype wire

@@ hw/rtl/bitsmp_dp.sv @@
// Datapath: fixed-point registers, shared multiplier and divider
`default_nettype none
`include "assert_macros.svh"
module bitsmp_dp #(
  parameter int MAX_TRIALS = bitsmp_pkg::MAX_TRIALS_DEF,
  parameter int FRAC_BITS  = bitsmp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bitsmp_pkg::op_t           op,
  input  wire logic [bitsmp_pkg::TW-1:0] trials,
  input  wire logic [bitsmp_pkg::PW-1:0] success_prob,
  input  wire logic                      reflect_mode,
  input  wire logic [bitsmp_pkg::UW-1:0] uniform_frac,
  output bitsmp_pkg::sts_t               sts,
  output logic      [bitsmp_pkg::TW-1:0] sample_count
);
  import bitsmp_pkg::*;

  localparam int W   = FRAC_BITS + 2;
  localparam int DVW = FRAC_BITS + 33;
  localparam int DSW = 33;
  localparam int SHL = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
  localparam int SHR = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;
  localparam int XW  = 33 + SHL;
  localparam int MT  = (MAX_TRIALS > 2047) ? 2047 : MAX_TRIALS;
  localparam logic [W-1:0] VMAX    = {W{1'b1}};
  localparam logic [W-1:0] ONE_FIX = W'(1) << FRAC_BITS;

  // Q0.32 (up to 1.0) to Q2.F
  function automatic logic [W-1:0] to_fix(input logic [32:0] v);
    logic [XW-1:0] t;
    t = XW'(v) << SHL;
    return W'(t >> SHR);
  endfunction

  logic [W-1:0]  acc_r, base_r, ratio_r, term_r, sum_r, alpha_r;
  logic [TW-1:0] mexp_r, k_r, sample_r;
  logic [TW-1:0] m, n;
  logic [32:0]   q, d;
  logic          mirror;
  logic [W-1:0]  mul_a, mul_b, mres, dres;
  logic          mul_start, div_start;
  logic [DVW-1:0] div_n;
  logic [DSW-1:0] div_d;
  logic [2*W-1:0] mprod;
  logic [DVW-1:0] dquot;
  logic          mul_done, div_done;
  logic [W:0]    sum_ext;

  // effective trials, reflected probability and its complement
  always_comb begin
    m      = (trials > TW'(MT)) ? TW'(MT) : trials;
    q      = (reflect_mode && (success_prob > HALF_Q32)) ?
             (33'h1_0000_0000 - {1'b0, success_prob}) : {1'b0, success_prob};
    d      = 33'h1_0000_0000 - q;
    mirror = reflect_mode && (success_prob >= HALF_Q32);
    n      = m - k_r + 1'b1;
  end

  // operand selection for the shared units
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = term_r;
    mul_b     = ratio_r;
    div_n     = DVW'(mprod);
    div_d     = DSW'(k_r);
    case (op)
      OP_MUL_ACC: begin
        mul_start = 1'b1;
        mul_a     = acc_r;
        mul_b     = base_r;
      end
      OP_MUL_SQ: begin
        mul_start = 1'b1;
        mul_a     = base_r;
        mul_b     = base_r;
      end
      OP_MUL_STEP: begin
        mul_start = 1'b1;
      end
      OP_MUL_SCALE: begin
        mul_start = 1'b1;
        mul_b     = W'(n);
      end
      OP_DIV_RATIO: begin
        div_start = 1'b1;
        div_n     = {q, {FRAC_BITS{1'b0}}};
        div_d     = d;
      end
      OP_DIV_SCALE: begin
        div_start = 1'b1;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  bitsmp_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mprod),
    .done  (mul_done)
  );

  bitsmp_div #(.NW(DVW), .DW(DSW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quot     (dquot),
    .done     (div_done)
  );

  // truncate and saturate unit results
  always_comb begin
    mres    = (|mprod[2*W-1:FRAC_BITS+W]) ? VMAX : mprod[FRAC_BITS+W-1:FRAC_BITS];
    dres    = (|dquot[DVW-1:W]) ? VMAX : dquot[W-1:0];
    sum_ext = {1'b0, sum_r} + {1'b0, dres};
  end

  // register updates per operation
  always_ff @(posedge clk) begin
    case (op)
      OP_INIT: begin
        acc_r  <= ONE_FIX;
        base_r <= to_fix(d);
        mexp_r <= m;
      end
      OP_LD_ACC:    acc_r <= mres;
      OP_LD_SQ: begin
        base_r <= mres;
        mexp_r <= mexp_r >> 1;
      end
      OP_LD_RATIO:  ratio_r <= dres;
      OP_SAT_RATIO: ratio_r <= VMAX;
      OP_LD_ITEM: begin
        alpha_r <= to_fix({1'b0, uniform_frac});
        term_r  <= acc_r;
        sum_r   <= acc_r;
        k_r     <= '0;
      end
      OP_MUL_STEP:  k_r <= k_r + 1'b1;
      OP_LD_MUL:    term_r <= mres;
      OP_LD_DIV: begin
        term_r <= dres;
        sum_r  <= sum_ext[W] ? VMAX : sum_ext[W-1:0];
      end
      OP_LD_OUT:    sample_r <= mirror ? (m - k_r) : k_r;
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  // status to the controller
  always_comb begin
    sts.mexp_zero = (mexp_r == '0);
    sts.mexp_lsb  = mexp_r[0];
    sts.ratio_big = {2'b00, q} >= {d, 2'b00};
    sts.cont      = (alpha_r > sum_r) && (k_r < m);
    sts.mul_done  = mul_done;
    sts.div_done  = div_done;
  end

  assign sample_count = sample_r;

  `ASSERT_RST(a_sum_covers_term, clk, rst_n, (op == OP_LD_DIV) |=> (sum_r >= term_r), "sum below term")
endmodule
`default_nettype wire

@@ hw/rtl/bitsmp_ctrl.sv @@
// Controller: sequences term derivation and the per-item search loop
`default_nettype none
`include "assert_macros.svh"
module bitsmp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire bitsmp_pkg::sts_t sts,
  output bitsmp_pkg::op_t       op
);
  import bitsmp_pkg::*;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_PCHK = 4'd1;
  localparam logic [3:0] S_PMA  = 4'd2;
  localparam logic [3:0] S_PSQS = 4'd3;
  localparam logic [3:0] S_PSQ  = 4'd4;
  localparam logic [3:0] S_PDIV = 4'd5;
  localparam logic [3:0] S_IDLE = 4'd6;
  localparam logic [3:0] S_TEST = 4'd7;
  localparam logic [3:0] S_SM1  = 4'd8;
  localparam logic [3:0] S_SSC  = 4'd9;
  localparam logic [3:0] S_SM2  = 4'd10;
  localparam logic [3:0] S_SDV  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state and datapath operation
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_INIT: begin
        op        = OP_INIT;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (sts.mexp_zero) begin
          if (sts.ratio_big) begin
            op        = OP_SAT_RATIO;
            state_nxt = S_IDLE;
          end else begin
            op        = OP_DIV_RATIO;
            state_nxt = S_PDIV;
          end
        end else if (sts.mexp_lsb) begin
          op        = OP_MUL_ACC;
          state_nxt = S_PMA;
        end else begin
          op        = OP_MUL_SQ;
          state_nxt = S_PSQ;
        end
      end
      S_PMA: begin
        if (sts.mul_done) begin
          op        = OP_LD_ACC;
          state_nxt = S_PSQS;
        end
      end
      S_PSQS: begin
        op        = OP_MUL_SQ;
        state_nxt = S_PSQ;
      end
      S_PSQ: begin
        if (sts.mul_done) begin
          op        = OP_LD_SQ;
          state_nxt = S_PCHK;
        end
      end
      S_PDIV: begin
        if (sts.div_done) begin
          op        = OP_LD_RATIO;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LD_ITEM;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.cont) begin
          op        = OP_MUL_STEP;
          state_nxt = S_SM1;
        end else if (out_free) begin
          op        = OP_LD_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_SM1: begin
        if (sts.mul_done) begin
          op        = OP_LD_MUL;
          state_nxt = S_SSC;
        end
      end
      S_SSC: begin
        op        = OP_MUL_SCALE;
        state_nxt = S_SM2;
      end
      S_SM2: begin
        if (sts.mul_done) begin
          op        = OP_DIV_SCALE;
          state_nxt = S_SDV;
        end
      end
      S_SDV: begin
        if (sts.div_done) begin
          op        = OP_LD_DIV;
          state_nxt = S_TEST;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
    // a register write rederives the terms
    if (cfg_wr) begin
      state_nxt = S_INIT;
    end
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (op == OP_LD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `ASSERT_RST(a_result_from_test, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_TEST), "result outside search end")
endmodule
`default_nettype wire

@@ hw/rtl/binomial_inverse_transform_sampler_top.sv @@
// Top level: APB registers, controller and datapath of the binomial sampler
//
//  channel  | direction | transaction contents
//  ---------+-----------+------------------------------------------
//  in_ch    | sink      | uniform_frac, Q0.32 uniform in [0,1)
//  out_ch   | source    | sample_count, binomial 0..min(trials, MAX_TRIALS)
//  cfg_*    | APB slave | trials @0x0, success_prob @0x4, reflect_mode @0x8
//
// One item at a time: each item is taken, then tested; every search step runs two
// products on the bit-serial multiplier and one quotient on the restoring divider
// before the next test. The result is valid the cycle after the final test.
// After reset and after every register write the terms (1-q)^m and q/(1-q) are
// rederived: (1-q)^m by square-and-multiply over the bits of m, q/(1-q) by
// division or saturated when q >= 4(1-q); no input is taken meanwhile.
// A result waits in the output register; the next item is taken meanwhile.
// Reset is synchronous, active low.
`default_nettype none
module binomial_inverse_transform_sampler_top #(
  parameter int MAX_TRIALS = bitsmp_pkg::MAX_TRIALS_DEF,
  parameter int FRAC_BITS  = bitsmp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bitsmp_in_if.sink                          in_ch,
  bitsmp_out_if.source                       out_ch,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [bitsmp_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [bitsmp_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [bitsmp_pkg::DATA_W-1:0] cfg_prdata,
  output logic                               cfg_pready
);
  import bitsmp_pkg::*;

  logic [TW-1:0] trials_r;
  logic [PW-1:0] prob_r;
  logic          reflect_r;
  logic          wr_en, cfg_wr;
  logic [1:0]    idx;
  op_t           op;
  sts_t          sts;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // register write decode
  always_comb begin
    unique case (idx)
      REG_TRIALS, REG_PROB, REG_REFLECT: cfg_wr = wr_en;
      default:                           cfg_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trials_r  <= TRIALS_RST;
      prob_r    <= PROB_RST;
      reflect_r <= REFLECT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_TRIALS:  trials_r  <= cfg_pwdata[TW-1:0];
        REG_PROB:    prob_r    <= cfg_pwdata[PW-1:0];
        REG_REFLECT: reflect_r <= cfg_pwdata[0];
        default:     trials_r  <= trials_r;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (idx)
      REG_TRIALS:  cfg_prdata = DATA_W'(trials_r);
      REG_PROB:    cfg_prdata = DATA_W'(prob_r);
      REG_REFLECT: cfg_prdata = DATA_W'(reflect_r);
      default:     cfg_prdata = '0;
    endcase
  end

  bitsmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .op        (op)
  );

  bitsmp_dp #(.MAX_TRIALS(MAX_TRIALS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .trials       (trials_r),
    .success_prob (prob_r),
    .reflect_mode (reflect_r),
    .uniform_frac (in_ch.uniform_frac),
    .sts          (sts),
    .sample_count (out_ch.sample_count)
  );
endmodule
`default_nettype wire
